>>> rtl/cca_pkg.sv
// calendar clock package: word types, cell control struct, calendar constants
// and helper functions. no dependencies; cca_cell and the top level import it.
package cca_pkg;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [1:0] REG_ALARM_ENABLE = 2'd0;
	localparam logic [1:0] REG_ALARM_HOUR   = 2'd1;
	localparam logic [1:0] REG_ALARM_MINUTE = 2'd2;

	localparam int CFG_DATA_W = 6;

	// reset time: 05:29:00, 26 april 2012
	localparam logic [5:0] RST_SEC   = 6'd0;
	localparam logic [5:0] RST_MIN   = 6'd29;
	localparam logic [4:0] RST_HOUR  = 5'd5;
	localparam logic [4:0] RST_DAY   = 5'd26;
	localparam logic [3:0] RST_MONTH = 4'd4;
	localparam logic [6:0] RST_YY    = 7'd12;
	localparam logic [6:0] RST_CENT  = 7'd20;

	localparam logic [5:0]  SEC_MAX   = 6'd59;
	localparam logic [5:0]  MIN_MAX   = 6'd59;
	localparam logic [4:0]  HOUR_MAX  = 5'd23;
	localparam logic [3:0]  MONTH_MAX = 4'd12;
	localparam logic [6:0]  YY_MAX    = 7'd99;
	localparam logic [6:0]  CENT_MAX  = 7'd99;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;

	// floor(y / 100) = (y * 5243) >> 19 for every y up to 16383
	localparam logic [26:0] CENT_RECIP = 27'd5243;
	localparam int          CENT_SHIFT = 19;

	typedef struct packed {
		logic        command;
		logic [5:0]  load_second;
		logic [5:0]  load_minute;
		logic [4:0]  load_hour;
		logic [4:0]  load_day;
		logic [3:0]  load_month;
		logic [13:0] load_year;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        leap_year;
		logic        alarm_match;
		logic        load_error;
	} out_word_t;

	// control handed to each counter cell
	typedef struct packed {
		logic step;
		logic load;
	} cca_ctl_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// year = cent * 100 + yy, so year mod 4 equals yy mod 4
	function automatic logic is_leap(input logic [6:0] yy, input logic [6:0] cent);
		return (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cent[1:0] == 2'd0));
	endfunction

endpackage

>>> rtl/cca_stream_if.sv
// valid/ready channel carrying one word of a given type.
// depends on nothing; the word type comes from cca_pkg at instantiation.
interface cca_stream_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cca_cell.sv
// one counter cell of the calendar chain: holds a field, loads it, steps or wraps on
// carry-in and hands its carry to the next cell. depends on cca_pkg.
module cca_cell #(
	parameter int              W           = 6,
	parameter logic [W-1:0]    RESET_VALUE = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cca_pkg::cca_ctl_t ctl,
	input  logic [W-1:0]      load_value,
	input  logic [W-1:0]      limit,
	input  logic [W-1:0]      wrap_value,
	output logic [W-1:0]      value,
	output logic [W-1:0]      next_value,
	output logic              carry
);
	import cca_pkg::*;

	logic [W-1:0] value_q;
	logic         below;

	assign below = value_q < limit;
	assign carry = ctl.step && !ctl.load && !below;
	assign value = value_q;

	always_comb begin
		if (ctl.load) begin
			next_value = load_value;
		end else if (ctl.step) begin
			next_value = below ? value_q + W'(1) : wrap_value;
		end else begin
			next_value = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= RESET_VALUE;
		end else begin
			value_q <= next_value;
		end
	end

endmodule

>>> rtl/calendar_clock_with_alarm.sv
// calendar clock top level: input stage, chain of counter cells, output register.
// depends on cca_pkg, cca_stream_if and cca_cell.
//
//  channel  | dir | word                                  | handshake
//  ---------+-----+---------------------------------------+-------------
//  item     | in  | command + load_* time/date fields     | valid/ready
//  result   | out | time/date, leap_year, alarm, load_err | valid/ready
//  cfg      | in  | cfg_index, cfg_wdata                  | cfg_wen only
//
// one word per cycle sustained while results are taken; a word passes the s1 register
// (which holds the load year's century from a reciprocal multiply), then the cell chain
// updates and the result register captures the new time
// reset: 05:29:00, 26 april 2012, alarm disabled, pipeline empty
// a result not taken stalls s1 and the cells; item.ready drops at once
module calendar_clock_with_alarm (
	input  logic                             clk,
	input  logic                             arst_n,
	cca_stream_if.sink                       item,
	cca_stream_if.source                     result,
	input  logic                             cfg_wen,
	input  logic [1:0]                       cfg_index,
	input  logic [cca_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import cca_pkg::*;

	// alarm registers
	logic       alarm_en_q;
	logic [4:0] alarm_hour_q;
	logic [5:0] alarm_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_en_q   <= 1'b0;
			alarm_hour_q <= '0;
			alarm_min_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ALARM_ENABLE: alarm_en_q   <= cfg_wdata[0];
				REG_ALARM_HOUR:   alarm_hour_q <= cfg_wdata[4:0];
				REG_ALARM_MINUTE: alarm_min_q  <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// pipeline advances whenever the result register is free or being drained
	logic       adv;
	logic       res_valid_q;
	out_word_t  res_q;

	assign adv        = !res_valid_q || result.ready;
	assign item.ready = adv;

	// stage 1: capture the word, split the load year into centuries
	logic        v_s1;
	in_word_t    word_s1;
	logic [7:0]  cent_s1;
	logic [26:0] cent_prod;

	assign cent_prod = 27'(item.data.load_year) * CENT_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item.valid) begin
			word_s1 <= item.data;
			cent_s1 <= cent_prod[26:CENT_SHIFT];
		end
	end

	// load check: remainder of the year, leap rule, field ranges
	logic [14:0] yy_diff;
	logic [6:0]  yy_ld;
	logic        leap_ld;
	logic        load_ok;
	logic        fire;

	assign yy_diff = 15'(word_s1.load_year) - 15'(cent_s1) * 15'd100;
	assign yy_ld   = yy_diff[6:0];
	assign leap_ld = is_leap(yy_ld, cent_s1[6:0]);
	assign load_ok = (word_s1.load_second <= SEC_MAX) && (word_s1.load_minute <= MIN_MAX)
		&& (word_s1.load_hour <= HOUR_MAX) && (word_s1.load_year <= YEAR_MAX)
		&& (word_s1.load_month >= 4'd1) && (word_s1.load_month <= MONTH_MAX)
		&& (word_s1.load_day >= 5'd1)
		&& (word_s1.load_day <= month_len(word_s1.load_month, leap_ld));
	assign fire = v_s1 && adv;

	// cell chain: sec -> min -> hour -> day -> month -> year in century -> century
	cca_ctl_t   ctl_sec, ctl_min, ctl_hour, ctl_day, ctl_month, ctl_yy, ctl_cent;
	logic       do_load;
	logic       c_sec, c_min, c_hour, c_day, c_month, c_yy, c_cent;
	logic [5:0] sec_q, sec_d, min_q, min_d;
	logic [4:0] hour_q, hour_d, day_q, day_d;
	logic [3:0] month_q, month_d;
	logic [6:0] yy_q, yy_d, cent_q, cent_d;
	logic       leap_q;
	logic [4:0] day_limit;

	assign do_load   = fire && (word_s1.command == CMD_LOAD) && load_ok;
	assign leap_q    = is_leap(yy_q, cent_q);
	assign day_limit = month_len(month_q, leap_q);

	assign ctl_sec   = '{step: fire && (word_s1.command == CMD_TICK), load: do_load};
	assign ctl_min   = '{step: c_sec,   load: do_load};
	assign ctl_hour  = '{step: c_min,   load: do_load};
	assign ctl_day   = '{step: c_hour,  load: do_load};
	assign ctl_month = '{step: c_day,   load: do_load};
	assign ctl_yy    = '{step: c_month, load: do_load};
	assign ctl_cent  = '{step: c_yy,    load: do_load};

	cca_cell #(.W(6), .RESET_VALUE(RST_SEC)) u_sec (
		.clk, .arst_n, .ctl(ctl_sec), .load_value(word_s1.load_second),
		.limit(SEC_MAX), .wrap_value(6'd0), .value(sec_q), .next_value(sec_d),
		.carry(c_sec)
	);

	cca_cell #(.W(6), .RESET_VALUE(RST_MIN)) u_min (
		.clk, .arst_n, .ctl(ctl_min), .load_value(word_s1.load_minute),
		.limit(MIN_MAX), .wrap_value(6'd0), .value(min_q), .next_value(min_d),
		.carry(c_min)
	);

	cca_cell #(.W(5), .RESET_VALUE(RST_HOUR)) u_hour (
		.clk, .arst_n, .ctl(ctl_hour), .load_value(word_s1.load_hour),
		.limit(HOUR_MAX), .wrap_value(5'd0), .value(hour_q), .next_value(hour_d),
		.carry(c_hour)
	);

	// day limit follows the current month and leap year
	cca_cell #(.W(5), .RESET_VALUE(RST_DAY)) u_day (
		.clk, .arst_n, .ctl(ctl_day), .load_value(word_s1.load_day),
		.limit(day_limit), .wrap_value(5'd1), .value(day_q), .next_value(day_d),
		.carry(c_day)
	);

	cca_cell #(.W(4), .RESET_VALUE(RST_MONTH)) u_month (
		.clk, .arst_n, .ctl(ctl_month), .load_value(word_s1.load_month),
		.limit(MONTH_MAX), .wrap_value(4'd1), .value(month_q), .next_value(month_d),
		.carry(c_month)
	);

	cca_cell #(.W(7), .RESET_VALUE(RST_YY)) u_yy (
		.clk, .arst_n, .ctl(ctl_yy), .load_value(yy_ld),
		.limit(YY_MAX), .wrap_value(7'd0), .value(yy_q), .next_value(yy_d),
		.carry(c_yy)
	);

	// century wraps 99 -> 0, which takes year 9999 back to 0
	cca_cell #(.W(7), .RESET_VALUE(RST_CENT)) u_cent (
		.clk, .arst_n, .ctl(ctl_cent), .load_value(cent_s1[6:0]),
		.limit(CENT_MAX), .wrap_value(7'd0), .value(cent_q), .next_value(cent_d),
		.carry(c_cent)
	);

	// result word from the state after this step
	out_word_t res_d;

	always_comb begin
		res_d.second      = sec_d;
		res_d.minute      = min_d;
		res_d.hour        = hour_d;
		res_d.day         = day_d;
		res_d.month       = month_d;
		res_d.year        = 14'(cent_d) * 14'd100 + 14'(yy_d);
		res_d.leap_year   = is_leap(yy_d, cent_d);
		res_d.alarm_match = alarm_en_q && (hour_d == alarm_hour_q) && (min_d == alarm_min_q);
		res_d.load_error  = (word_s1.command == CMD_LOAD) && !load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

`ifndef SYNTHESIS
	// state only moves when a word passes the cell chain
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(sec_q) && $stable(min_q) && $stable(hour_q) && $stable(day_q)
			&& $stable(month_q) && $stable(yy_q) && $stable(cent_q)))
		else $error("calendar state changed without a word in flight");

	// a rejected load leaves the seconds, day, year and century cells alone and flags the result
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (word_s1.command == CMD_LOAD) && !load_ok) |=>
			($stable(sec_q) && $stable(day_q) && $stable(cent_q) && $stable(yy_q)
			&& res_valid_q && res_q.load_error))
		else $error("rejected load altered state or was not flagged");

	// a tick below 59 seconds steps the seconds by one and leaves the minutes alone
	a_tick_sec: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (word_s1.command == CMD_TICK) && (sec_q < SEC_MAX)) |=>
			((sec_q == $past(sec_q) + 6'd1) && $stable(min_q)))
		else $error("seconds tick did not step by one");

	// the day always lies within the current month, and the month within 1 to 12
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(day_q >= 5'd1) && (day_q <= day_limit) && (month_q >= 4'd1) && (month_q <= MONTH_MAX))
		else $error("calendar day or month out of range");
`endif

endmodule
